// ===== hdl/ttc_pkg.sv =====
// Shared constants and types for the text terminal cursor controller.
`default_nettype none

package ttc_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 64;
    localparam int DEF_ROWS    = 16;

    // Fixed field widths of the ports.
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 10;
    localparam int POS_W  = 10;

    // Operation codes carried by the op field.
    localparam logic OP_STROBE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Character and control codes.
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CODE_LEFT  = 8'h0F;
    localparam logic [CHAR_W-1:0] CODE_DEL   = 8'h7F;
    localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7E;
    localparam logic [CHAR_W-1:0] BLANK      = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_CELL = 8'h00;

    // Memory work requested by a decoded character strobe.
    typedef struct packed {
        logic              write;
        logic [CHAR_W-1:0] wdata;
        logic              scroll;
        logic              clear;
    } t_action;

    // Status of the memory sequencer toward the top level.
    typedef struct packed {
        logic idle;
        logic rd_done;
    } t_seq_status;

endpackage

`default_nettype wire

// ===== hdl/ttc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ttc_ram #(
    parameter int  WIDTH = ttc_pkg::CHAR_W,
    parameter int  DEPTH = ttc_pkg::DEF_COLUMNS * ttc_pkg::DEF_ROWS,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/ttc_cursor.sv =====
// Cursor registers and character code decoder.
`default_nettype none

module ttc_cursor #(
    parameter int  COLUMNS = ttc_pkg::DEF_COLUMNS,
    parameter int  ROWS    = ttc_pkg::DEF_ROWS,
    localparam int AW      = $clog2(COLUMNS * ROWS),
    localparam int RW      = $clog2(ROWS),
    localparam int CLW     = $clog2(COLUMNS)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_go,
    input  wire logic [ttc_pkg::CHAR_W-1:0]   i_char_code,
    output ttc_pkg::t_action                  o_act,
    output logic      [AW-1:0]                o_cur,
    output logic      [AW-1:0]                o_next_cur
);

    localparam logic [RW-1:0]  LAST_ROW = RW'(ROWS - 1);
    localparam logic [CLW-1:0] LAST_COL = CLW'(COLUMNS - 1);

    logic [RW-1:0]  r_row, n_row;
    logic [CLW-1:0] r_col, n_col;
    logic [AW-1:0]  r_cur, n_cur;

    // The linear index is kept next to row and column so that no
    // multiply or divide is needed on the update path.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_cur = r_cur;
        o_act = '0;
        if (i_go) begin
            case (i_char_code)
                ttc_pkg::CODE_LF: begin
                    if (r_row == LAST_ROW) begin
                        o_act.scroll = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                        n_cur = r_cur + AW'(COLUMNS);
                    end
                end
                ttc_pkg::CODE_CR: begin
                    n_col = '0;
                    n_cur = r_cur - AW'(r_col);
                end
                ttc_pkg::CODE_FF: begin
                    n_row       = '0;
                    n_col       = '0;
                    n_cur       = '0;
                    o_act.clear = 1'b1;
                end
                ttc_pkg::CODE_LEFT: begin
                    if (r_cur != '0) begin
                        n_cur = r_cur - 1'b1;
                        if (r_col == '0) begin
                            n_col = LAST_COL;
                            n_row = r_row - 1'b1;
                        end else begin
                            n_col = r_col - 1'b1;
                        end
                    end
                end
                ttc_pkg::CODE_DEL: begin
                    o_act.write = 1'b1;
                    o_act.wdata = ttc_pkg::BLANK;
                end
                default: begin
                    if (i_char_code >= ttc_pkg::PRINT_LO &&
                        i_char_code <= ttc_pkg::PRINT_HI) begin
                        o_act.write = 1'b1;
                        o_act.wdata = i_char_code;
                        if (r_col == LAST_COL) begin
                            n_col = '0;
                            if (r_row == LAST_ROW) begin
                                // Wrap off the last cell: back to the start
                                // of the bottom row, then scroll.
                                n_cur        = r_cur - AW'(COLUMNS - 1);
                                o_act.scroll = 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                                n_cur = r_cur + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                            n_cur = r_cur + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_cur <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_cur <= n_cur;
        end
    end

    assign o_cur      = r_cur;
    assign o_next_cur = n_cur;

    a_cur_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cur) == int'(r_row) * COLUMNS + int'(r_col))
        else $error("cursor index does not match row and column");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) < COLUMNS && int'(r_row) < ROWS)
        else $error("cursor row or column out of range");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_act.scroll |-> (r_row == LAST_ROW && n_row == LAST_ROW))
        else $error("scroll requested off the bottom row");

endmodule

`default_nettype wire

// ===== hdl/ttc_seq.sv =====
// Screen memory sequencer: cell writes, reads, scroll and clear sweeps.
`default_nettype none

module ttc_seq #(
    parameter int  COLUMNS = ttc_pkg::DEF_COLUMNS,
    parameter int  ROWS    = ttc_pkg::DEF_ROWS,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int AW      = $clog2(CELLS)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_go_strobe,
    input  wire logic                         i_go_read,
    input  wire ttc_pkg::t_action             i_act,
    input  wire logic [AW-1:0]                i_cur,
    input  wire logic [ttc_pkg::ADDR_W-1:0]   i_read_address,
    output logic      [ttc_pkg::CHAR_W-1:0]   o_cell,
    output ttc_pkg::t_seq_status              o_status
);

    // One bit above the wider of the two address widths, so that the cell
    // count itself fits in the range compare.
    localparam int XW = ((AW > ttc_pkg::ADDR_W) ? AW : ttc_pkg::ADDR_W) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_LEN   = AW'(COLUMNS);
    localparam logic [AW-1:0] BOT_ROW   = AW'(CELLS - COLUMNS);

    logic [2:0]                 r_state, n_state;
    logic [AW-1:0]              r_ptr, n_ptr;
    logic [AW-1:0]              r_src, n_src;
    logic [AW-1:0]              r_dst, n_dst;
    logic                       r_pend, n_pend;
    logic                       r_ok, n_ok;
    logic [ttc_pkg::CHAR_W-1:0] r_fill, n_fill;

    logic [XW-1:0]              addr_x;
    logic                       addr_ok;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [AW-1:0]              raddr;
    logic [ttc_pkg::CHAR_W-1:0] wdata;
    logic [ttc_pkg::CHAR_W-1:0] rdata;

    assign addr_x  = XW'(i_read_address);
    assign addr_ok = addr_x < XW'(CELLS);

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_src   = r_src;
        n_dst   = r_dst;
        n_pend  = r_pend;
        n_ok    = r_ok;
        n_fill  = r_fill;
        we      = 1'b0;
        waddr   = r_ptr;
        wdata   = r_fill;
        raddr   = r_src;
        case (r_state)
            S_IDLE: begin
                raddr = addr_x[AW-1:0];
                waddr = i_cur;
                wdata = i_act.wdata;
                we    = i_go_strobe && i_act.write;
                if (i_go_read) begin
                    n_ok    = addr_ok;
                    n_state = S_READ;
                end else if (i_go_strobe && i_act.clear) begin
                    n_ptr   = '0;
                    n_fill  = ttc_pkg::BLANK;
                    n_state = S_FILL;
                end else if (i_go_strobe && i_act.scroll) begin
                    n_src   = ROW_LEN;
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            S_SHIFT: begin
                // Read one row below, write it back in the next cycle.
                we     = r_pend;
                waddr  = r_dst;
                wdata  = rdata;
                n_pend = 1'b1;
                n_dst  = r_src - ROW_LEN;
                if (r_src == LAST_CELL) begin
                    n_state = S_LAST;
                end else begin
                    n_src = r_src + 1'b1;
                end
            end
            S_LAST: begin
                we      = 1'b1;
                waddr   = r_dst;
                wdata   = rdata;
                n_pend  = 1'b0;
                n_ptr   = BOT_ROW;
                n_fill  = ttc_pkg::BLANK;
                n_state = S_FILL;
            end
            S_FILL: begin
                we = 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Reset starts a sweep that zeros every cell.
            r_state <= S_FILL;
            r_ptr   <= '0;
            r_fill  <= ttc_pkg::RESET_CELL;
            r_pend  <= 1'b0;
            r_src   <= '0;
            r_dst   <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_ok    <= n_ok;
        end
    end

    ttc_ram #(
        .WIDTH (ttc_pkg::CHAR_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_cell           = r_ok ? rdata : '0;
    assign o_status.idle    = (r_state == S_IDLE);
    assign o_status.rd_done = (r_state == S_READ);

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend) |-> (r_src > r_dst))
        else $error("scroll read does not lead its write-back");

    a_last_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |=> (r_state == S_FILL && r_ptr == BOT_ROW))
        else $error("scroll did not blank the bottom row");

    a_no_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go_strobe || i_go_read) |-> (r_state == S_IDLE))
        else $error("word started while the sequencer is busy");

endmodule

`default_nettype wire

// ===== hdl/text_terminal_cursor_controller_unit.sv =====
// Top level of the text terminal cursor controller: handshakes and result register.
//
//  Channel  Direction  Handshake            Fields
//  -------  ---------  -------------------  ---------------------------------------------
//  input    in         i_valid / o_stall    i_op, i_strobe_level, i_char_code,
//                                           i_read_address
//  output   out        o_valid / i_stall    o_cell_value, o_cursor_position
//
//  After reset the block sweeps the screen memory to zeros, one cell a cycle, and
//  holds o_stall high until that sweep is done.
//  A strobe word that only moves the cursor or writes one cell leaves the sequencer
//  idle; a read word passes through S_READ for the registered memory read.
//  A clear and a scroll both sweep the screen memory through its single write port,
//  one cell a cycle.
//  The next word is taken only when the memory sequencer is idle and the result
//  register is empty or being emptied; a stalled result is held in that register.
`default_nettype none

module text_terminal_cursor_controller_unit #(
    parameter int COLUMNS = ttc_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttc_pkg::DEF_ROWS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_op,
    input  wire logic                         i_strobe_level,
    input  wire logic [ttc_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [ttc_pkg::ADDR_W-1:0]   i_read_address,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [ttc_pkg::CHAR_W-1:0]   o_cell_value,
    output logic      [ttc_pkg::POS_W-1:0]    o_cursor_position
);

    localparam int AW = $clog2(COLUMNS * ROWS);
    // The reported position is the cursor index, widened or cut to the port width.
    localparam int CW = (AW > ttc_pkg::POS_W) ? AW : ttc_pkg::POS_W;

    ttc_pkg::t_action     act;
    ttc_pkg::t_seq_status stat;

    logic                       accept;
    logic                       go_strobe;
    logic                       go_read;
    logic [AW-1:0]              cur;
    logic [AW-1:0]              next_cur;
    logic [ttc_pkg::CHAR_W-1:0] seq_cell;
    logic [CW-1:0]              next_pos_x;
    logic [CW-1:0]              cur_pos_x;

    logic                       r_out_valid, n_out_valid;
    logic [ttc_pkg::CHAR_W-1:0] r_cell, n_cell;
    logic [ttc_pkg::POS_W-1:0]  r_pos, n_pos;

    // A word is taken when the sequencer is idle and the result slot frees up.
    assign o_stall   = !stat.idle || (r_out_valid && i_stall);
    assign accept    = i_valid && !o_stall;
    assign go_strobe = accept && (i_op == ttc_pkg::OP_STROBE) && i_strobe_level;
    assign go_read   = accept && (i_op == ttc_pkg::OP_READ);

    ttc_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go_strobe),
        .i_char_code (i_char_code),
        .o_act       (act),
        .o_cur       (cur),
        .o_next_cur  (next_cur)
    );

    ttc_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go_strobe    (go_strobe),
        .i_go_read      (go_read),
        .i_act          (act),
        .i_cur          (cur),
        .i_read_address (i_read_address),
        .o_cell         (seq_cell),
        .o_status       (stat)
    );

    assign next_pos_x = CW'(next_cur);
    assign cur_pos_x  = CW'(cur);

    // A strobe word's result is known at acceptance: its cursor after the step
    // and a zero cell. Any scroll or clear it starts runs on behind it, and
    // the next word waits for that. A read word's result is loaded in the
    // S_READ state, when the memory data is out.
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        n_cell      = r_cell;
        n_pos       = r_pos;
        if (accept && (i_op == ttc_pkg::OP_STROBE)) begin
            n_out_valid = 1'b1;
            n_cell      = '0;
            n_pos       = next_pos_x[ttc_pkg::POS_W-1:0];
        end else if (stat.rd_done) begin
            n_out_valid = 1'b1;
            n_cell      = seq_cell;
            n_pos       = cur_pos_x[ttc_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_cell <= n_cell;
        r_pos  <= n_pos;
    end

    assign o_valid           = r_out_valid;
    assign o_cell_value      = r_cell;
    assign o_cursor_position = r_pos;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((accept && (i_op == ttc_pkg::OP_STROBE)) || stat.rd_done)
            |-> (!r_out_valid || !i_stall))
        else $error("result register overwritten while stalled");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == ttc_pkg::OP_READ)) |=> stat.rd_done)
        else $error("read word did not complete in the next cycle");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid || stat.rd_done)
        else $error("accepted word produced no result");

endmodule

`default_nettype wire

// ===== tb/tb_text_terminal_cursor_controller_unit.sv =====
// Self-checking testbench for the text terminal cursor controller unit.
module tb_text_terminal_cursor_controller_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS        = ttc_pkg::DEF_COLUMNS;
    localparam int LINES       = ttc_pkg::DEF_ROWS;
    localparam int CELLS       = COLS * LINES;
    localparam int TOTAL_WORDS = 580;
    // A clear or scroll takes one full pass over the store, so the drain after
    // the last result waits out one such pass.
    localparam int END_WAIT    = CELLS + 16;
    // Slowest correct run: every word a scroll, behind the longest sender gap
    // and the longest receiver stall, plus the clearing pass after reset;
    // the limit is several times that.
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [ttc_pkg::CHAR_W-1:0] cell_val;
        logic [ttc_pkg::POS_W-1:0]  pos;
    } t_screen_readback;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic                       i_op           = ttc_pkg::OP_STROBE;
    logic                       i_strobe_level = 1'b0;
    logic [ttc_pkg::CHAR_W-1:0] i_char_code    = '0;
    logic [ttc_pkg::ADDR_W-1:0] i_read_address = '0;
    logic                       i_stall        = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [ttc_pkg::CHAR_W-1:0] o_cell_value;
    logic [ttc_pkg::POS_W-1:0]  o_cursor_position;

    // Our own copy of the screen store and the write cursor.
    logic [ttc_pkg::CHAR_W-1:0] screen_model [CELLS];
    int unsigned                cursor_model;

    t_screen_readback pending_readback [$];
    int               mismatch_count = 0;
    int               words_sent     = 0;
    int               burst_left     = 0;
    int               cycle_count    = 0;

    text_terminal_cursor_controller_unit #(
        .COLUMNS(COLS),
        .ROWS   (LINES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_strobe_level   (i_strobe_level),
        .i_char_code      (i_char_code),
        .i_read_address   (i_read_address),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cell_value     (o_cell_value),
        .o_cursor_position(o_cursor_position)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Move every row up by one and blank the new bottom row.
    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLS; i++) begin
            screen_model[i] = screen_model[i + COLS];
        end
        for (int i = CELLS - COLS; i < CELLS; i++) begin
            screen_model[i] = ttc_pkg::BLANK;
        end
    endfunction

    // Apply one accepted word to the screen model and return the readback it causes.
    function automatic t_screen_readback update_screen_model(input logic op,
            input logic level, input logic [ttc_pkg::CHAR_W-1:0] code,
            input logic [ttc_pkg::ADDR_W-1:0] addr);
        t_screen_readback r;
        r.cell_val = '0;
        if (op == ttc_pkg::OP_READ) begin
            if (int'(addr) < CELLS) begin
                r.cell_val = screen_model[addr];
            end
        end else if (level) begin
            case (code)
                ttc_pkg::CODE_LF: begin
                    if (cursor_model >= CELLS - COLS) begin
                        scroll_screen();
                    end else begin
                        cursor_model += COLS;
                    end
                end
                ttc_pkg::CODE_CR: begin
                    cursor_model -= cursor_model % COLS;
                end
                ttc_pkg::CODE_FF: begin
                    cursor_model = 0;
                    for (int i = 0; i < CELLS; i++) begin
                        screen_model[i] = ttc_pkg::BLANK;
                    end
                end
                ttc_pkg::CODE_LEFT: begin
                    if (cursor_model != 0) begin
                        cursor_model--;
                    end
                end
                ttc_pkg::CODE_DEL: begin
                    screen_model[cursor_model] = ttc_pkg::BLANK;
                end
                default: begin
                    if (code >= ttc_pkg::PRINT_LO && code <= ttc_pkg::PRINT_HI) begin
                        screen_model[cursor_model] = code;
                        cursor_model++;
                        // Running off the last cell lands on the start of the bottom row.
                        if (cursor_model >= CELLS) begin
                            cursor_model -= COLS;
                            scroll_screen();
                        end
                    end
                end
            endcase
        end
        r.pos = cursor_model[ttc_pkg::POS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offer one word, honoring the burst and gap pattern of the sender, and
    // record what it should produce once the block takes it.
    task automatic send_word(input logic op, input logic level,
            input logic [ttc_pkg::CHAR_W-1:0] code,
            input logic [ttc_pkg::ADDR_W-1:0] addr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_op           <= op;
        i_strobe_level <= level;
        i_char_code    <= code;
        i_read_address <= addr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_readback.push_back(update_screen_model(op, level, code, addr));
        words_sent++;
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_readback.size() != 0);
    endtask

    task automatic test_after_reset();
        // The store must read back as zeros after the clearing pass.
        send_word(ttc_pkg::OP_READ, 1'b0, 8'h00, 10'd0);
        send_word(ttc_pkg::OP_READ, 1'b1, 8'hFF, 10'(CELLS - 1));
        drain_results();
    endtask

    task automatic test_control_codes();
        send_word(ttc_pkg::OP_STROBE, 1'b0, 8'h41, 10'd0);       // low level does nothing
        send_word(ttc_pkg::OP_STROBE, 1'b0, ttc_pkg::CODE_FF, 10'd0);   // not even a clear
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_LEFT, 10'd0); // left stops at zero
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::PRINT_LO, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::PRINT_HI, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, 8'h41, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_LEFT, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_DEL, 10'd0);
        send_word(ttc_pkg::OP_READ, 1'b0, 8'h00, 10'd2);
        send_word(ttc_pkg::OP_READ, 1'b1, 8'h55, 10'd1);
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_CR, 10'h3FF);
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_LF, 10'd0);
        // Codes outside the control set and the printable range are ignored.
        send_word(ttc_pkg::OP_STROBE, 1'b1, 8'h00, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, 8'h1F, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, 8'h80, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, 8'hFF, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, 8'h0B, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_FF, 10'd0);
        send_word(ttc_pkg::OP_READ, 1'b0, 8'h00, 10'(CELLS - 1));
        send_word(ttc_pkg::OP_READ, 1'b1, ttc_pkg::CODE_FF, 10'd0);
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_LF, 10'd0);
        drain_results();
    endtask

    task automatic test_run_off_end();
        // Fill the bottom row; the character that lands in its last cell scrolls.
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_FF, 10'd0);
        repeat (LINES - 1) send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_LF, 10'd0);
        repeat (COLS) begin
            send_word(ttc_pkg::OP_STROBE, 1'b1,
                      8'($urandom_range(ttc_pkg::PRINT_LO, ttc_pkg::PRINT_HI)),
                      10'($urandom));
        end
        send_word(ttc_pkg::OP_READ, 1'b0, 8'h00, 10'(CELLS - COLS - 1));
        send_word(ttc_pkg::OP_READ, 1'b0, 8'h00, 10'(CELLS - COLS));
        send_word(ttc_pkg::OP_READ, 1'b0, 8'h00, 10'(CELLS - 1));
        // A line feed on the bottom row scrolls and leaves the cursor alone.
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_LF, 10'd0);
        send_word(ttc_pkg::OP_READ, 1'b1, 8'h00, 10'(CELLS - 2 * COLS - 1));
        send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_CR, 10'd0);
        drain_results();
    endtask

    // Mostly lines of text ended by carriage return, line feed, both or neither,
    // mixed with reads, raw noise and the occasional clear.
    task automatic test_random_traffic(input int target);
        int kind;
        int len;
        int pick;
        int near;
        logic [ttc_pkg::CHAR_W-1:0] ch;
        while (words_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
                repeat (len) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 2) ch = ttc_pkg::CODE_LEFT;
                    else if (pick == 2) ch = ttc_pkg::CODE_DEL;
                    else ch = 8'($urandom_range(ttc_pkg::PRINT_LO, ttc_pkg::PRINT_HI));
                    send_word(ttc_pkg::OP_STROBE, 1'b1, ch, 10'($urandom));
                end
                pick = $urandom_range(0, 3);
                if (pick == 0 || pick == 2) begin
                    send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_CR, 10'($urandom));
                end
                if (pick <= 1) begin
                    send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_LF, 10'($urandom));
                end
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 2) == 0) begin
                        near = int'(cursor_model) + int'($urandom_range(0, 6)) - 3;
                        if (near < 0) near = 0;
                        if (near > CELLS - 1) near = CELLS - 1;
                    end else begin
                        near = $urandom_range(0, CELLS - 1);
                    end
                    send_word(ttc_pkg::OP_READ, 1'($urandom), 8'($urandom), 10'(near));
                end
            end else if (kind < 97) begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(1'($urandom), 1'($urandom), 8'($urandom_range(0, 255)),
                              10'($urandom_range(0, CELLS - 1)));
                end
            end else begin
                send_word(ttc_pkg::OP_STROBE, 1'b1, ttc_pkg::CODE_FF, 10'($urandom));
            end
            // Now and then the sender waits for every result before going on.
            if ($urandom_range(0, 24) == 0) drain_results();
        end
    endtask

    // The receiver stalls in phases: never, lightly, heavily, or solidly.
    int stall_mode       = 0;
    int stall_phase_left = 0;
    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_phase_left = (stall_mode == 3) ? $urandom_range(1, 20)
                                                 : $urandom_range(10, 200);
        end
        stall_phase_left--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= 1'b1;
        endcase
    end

    // Every word taken at the output is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_screen_readback want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readback.size() == 0) begin
                report_mismatch("result with nothing pending, cursor_position",
                                int'(o_cursor_position), -1);
            end else begin
                want = pending_readback.pop_front();
                if (o_cell_value !== want.cell_val) begin
                    report_mismatch("cell_value", int'(o_cell_value), int'(want.cell_val));
                end
                if (o_cursor_position !== want.pos) begin
                    report_mismatch("cursor_position", int'(o_cursor_position),
                                    int'(want.pos));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_terminal_cursor_controller_unit verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            screen_model[i] = ttc_pkg::RESET_CELL;
        end
        cursor_model = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_control_codes();
        test_run_off_end();
        test_random_traffic(TOTAL_WORDS);

        drain_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("text_terminal_cursor_controller_unit verification clean");
        end else begin
            $display("text_terminal_cursor_controller_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ttc_pkg.sv
hdl/ttc_ram.sv
hdl/ttc_cursor.sv
hdl/ttc_seq.sv
hdl/text_terminal_cursor_controller_unit.sv
tb/tb_text_terminal_cursor_controller_unit.sv
